// File: rtl/producer_sequence_dedup_table_defines.svh
// Assertion macros for the producer sequence dedup table
`ifndef PRODUCER_SEQUENCE_DEDUP_TABLE_DEFINES_SVH
`define PRODUCER_SEQUENCE_DEDUP_TABLE_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define PSDT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define PSDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/psdt_pkg.sv
// Shared types and constants for the producer sequence dedup table
`default_nettype none
package psdt_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int OUT_CNT_W = 7;
    localparam logic [31:0] EXPIRY_RESET = 32'd604800000;
    localparam logic [31:0] SEQ_MAX = 32'h7FFF_FFFF;
    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_BYPASSED = 2'd1;
    localparam logic [1:0] ST_OUT_OF_ORDER = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic        probe;     // match pass: compare key, report hit
        logic        write_hit; // write into the matched cell
        logic        write_new; // write into the claimed free cell
        logic        expire;    // drop entries older than cutoff
        logic [62:0] pid;
        logic [14:0] epoch;
        logic [31:0] seq;
        logic [47:0] wtime;
        logic signed [49:0] cutoff;
    } psdt_cmd_t;

    // Per-cell view handed back to the controller
    typedef struct packed {
        logic        hit;
        logic [31:0] seq;
        logic        valid;
        logic [47:0] wtime;
    } psdt_cell_stat_t;
endpackage
`default_nettype wire

// File: rtl/producer_sequence_dedup_table.sv
// An accepted request steps through the decide, count and output states; a taken apply request also passes expire.
// A new request is taken while idle, or as the previous result leaves; not while one is in progress.
// Key match, write, expiry and count each take a pass over the row of entry cells.
// Reset: rst_n asynchronous; clears all entries, oldest time to maximum, window to 604800000 ms.
`default_nettype none
module producer_sequence_dedup_table
    import psdt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               action,
    input  wire logic               idempotent,
    input  wire logic               is_data_batch,
    input  wire logic [62:0]        producer_id,
    input  wire logic [14:0]        producer_epoch,
    input  wire logic signed [31:0] seq_first,
    input  wire logic signed [31:0] seq_last,
    input  wire logic [47:0]        batch_time,
    input  wire logic [47:0]        now_time,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic [6:0]              entries_in_use,
    output logic [6:0]              expired_count
);
    psdt_cmd_t       cmd;
    psdt_cell_stat_t stat [TABLE_ENTRIES];
    logic [TABLE_ENTRIES:0] free_chain;
    psdt_cmd_t       cell_cmd;

    // the request probes every cell on acceptance (probe is high while idle or holding a result)
    assign free_chain[0] = 1'b0;

    psdt_ctrl u_ctrl (
        .clk, .rst_n, .cfg_we, .cfg_data, .in_valid, .in_ready, .action,
        .idempotent, .is_data_batch, .producer_id, .producer_epoch, .seq_first,
        .seq_last, .batch_time, .now_time, .out_valid, .out_ready, .status,
        .entries_in_use, .expired_count, .cmd, .stat,
        .any_free(free_chain[TABLE_ENTRIES])
    );

    // the probe key during idle or result hold comes from the incoming request
    always_comb
    begin
        cell_cmd = cmd;
        if (cmd.probe)
        begin
            cell_cmd.pid = producer_id;
            cell_cmd.epoch = producer_epoch;
        end
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        psdt_cell u_cell (
            .clk, .rst_n, .cmd(cell_cmd), .free_in(free_chain[g]),
            .free_out(free_chain[g+1]), .stat(stat[g])
        );
    end
endmodule
`default_nettype wire

// File: rtl/psdt_cell.sv
// One table entry: key compare, update and expiry
`default_nettype none
module psdt_cell
    import psdt_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire psdt_cmd_t       cmd,
    input  wire logic            free_in,   // a lower cell is free
    output logic                 free_out,
    output psdt_cell_stat_t      stat
);
    logic        valid_reg, valid_next;
    logic        hit_reg;
    logic [62:0] pid_reg;
    logic [14:0] epoch_reg;
    logic [31:0] seq_reg;
    logic [47:0] wtime_reg;
    logic        claim;
    logic        match;
    logic        old;

    assign match = valid_reg && pid_reg == cmd.pid && epoch_reg == cmd.epoch;
    // free token ripples down the row; first free cell takes it
    assign claim = !valid_reg && !free_in;
    assign free_out = free_in || !valid_reg;
    assign old = $signed({2'b00, wtime_reg}) < cmd.cutoff;

    always_comb
    begin
        valid_next = valid_reg;
        if ((cmd.write_hit && hit_reg) || (cmd.write_new && claim))
            valid_next = 1'b1;
        else if (cmd.expire && valid_reg && old)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cmd.probe)
                hit_reg <= match;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((cmd.write_hit && hit_reg) || (cmd.write_new && claim))
        begin
            pid_reg <= cmd.pid;
            epoch_reg <= cmd.epoch;
            seq_reg <= cmd.seq;
            wtime_reg <= cmd.wtime;
        end
    end

    assign stat.hit = hit_reg;
    assign stat.seq = seq_reg;
    assign stat.valid = valid_reg;
    assign stat.wtime = wtime_reg;
endmodule
`default_nettype wire

// File: rtl/psdt_ctrl.sv
// Sequencer: decode, decision, expiry, count and result register
`default_nettype none
module psdt_ctrl
    import psdt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [31:0]           cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  action,
    input  wire logic                  idempotent,
    input  wire logic                  is_data_batch,
    input  wire logic [62:0]           producer_id,
    input  wire logic [14:0]           producer_epoch,
    input  wire logic signed [31:0]    seq_first,
    input  wire logic signed [31:0]    seq_last,
    input  wire logic [47:0]           batch_time,
    input  wire logic [47:0]           now_time,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 status,
    output logic [OUT_CNT_W-1:0]       entries_in_use,
    output logic [OUT_CNT_W-1:0]       expired_count,
    output psdt_cmd_t                  cmd,
    input  wire psdt_cell_stat_t       stat [TABLE_ENTRIES],
    input  wire logic                  any_free
);
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_EXPIRE = 5'b00100,
        S_COUNT  = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] window_reg;
    logic [47:0] oldest_reg, oldest_next;
    logic        act_reg, take_reg;
    logic [62:0] pid_reg;
    logic [14:0] epoch_reg;
    logic [31:0] fseq_reg, lseq_reg;
    logic [47:0] btime_reg, now_reg;
    logic [1:0]  status_reg, status_next;
    logic [CNT_W-1:0] used_reg, removed_reg;
    logic        run_expiry;
    logic        any_hit;
    logic [31:0] hit_seq;
    logic        cont;
    logic        wr_hit, wr_new;
    logic signed [49:0] cutoff;
    logic [47:0] min_keep;
    logic [CNT_W-1:0] cnt_valid, cnt_old;
    logic        ordered;
    logic        accept;
    logic [TABLE_ENTRIES-1:0] old_vec;
    logic [47:0]      min_tree [1:2*TABLE_ENTRIES-1];
    logic [CNT_W-1:0] vcnt_tree [1:2*TABLE_ENTRIES-1];
    logic [CNT_W-1:0] ocnt_tree [1:2*TABLE_ENTRIES-1];

    assign ordered = seq_first <= seq_last;
    assign accept = in_valid && in_ready;
    assign in_ready = state_reg == S_IDLE || (state_reg == S_OUT && out_ready);
    assign cutoff = $signed({2'b00, now_reg}) - $signed({18'd0, window_reg});

    // matched cell: at most one hit
    always_comb
    begin
        any_hit = 1'b0;
        hit_seq = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            any_hit = any_hit | stat[i].hit;
            hit_seq = hit_seq | (stat[i].hit ? stat[i].seq : 32'd0);
        end
    end

    assign cont = (hit_seq + 32'd1 == fseq_reg) || (fseq_reg == '0 && hit_seq == SEQ_MAX);

    always_comb
    begin
        wr_hit = 1'b0;
        wr_new = 1'b0;
        status_next = ST_BYPASSED;
        if (!act_reg)
        begin
            if (!any_hit)
            begin
                if (fseq_reg != '0)
                    status_next = ST_OUT_OF_ORDER;
                else if (!any_free)
                    status_next = ST_TABLE_FULL;
                else
                begin
                    wr_new = 1'b1;
                    status_next = ST_ACCEPTED;
                end
            end
            else if (!cont)
                status_next = ST_OUT_OF_ORDER;
            else
            begin
                wr_hit = 1'b1;
                status_next = ST_ACCEPTED;
            end
        end
        else
        begin
            if (!any_hit)
            begin
                if (!any_free)
                    status_next = ST_TABLE_FULL;
                else
                begin
                    wr_new = 1'b1;
                    status_next = ST_ACCEPTED;
                end
            end
            else if ($signed(hit_seq) < $signed(lseq_reg))
            begin
                wr_hit = 1'b1;
                status_next = ST_ACCEPTED;
            end
        end
    end

    // per-cell age test against the cutoff
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
            old_vec[i] = stat[i].valid && ($signed({2'b00, stat[i].wtime}) < cutoff);
    end

    // population counts and surviving minimum, reduced as a balanced tree
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            vcnt_tree[TABLE_ENTRIES + i] = CNT_W'(stat[i].valid);
            ocnt_tree[TABLE_ENTRIES + i] = CNT_W'(old_vec[i]);
            min_tree[TABLE_ENTRIES + i] = (stat[i].valid && !old_vec[i]) ?
                                          stat[i].wtime : now_reg;
        end
        for (int n = TABLE_ENTRIES - 1; n >= 1; n--)
        begin
            vcnt_tree[n] = vcnt_tree[2*n] + vcnt_tree[2*n+1];
            ocnt_tree[n] = ocnt_tree[2*n] + ocnt_tree[2*n+1];
            min_tree[n] = (min_tree[2*n+1] < min_tree[2*n]) ? min_tree[2*n+1] : min_tree[2*n];
        end
    end

    assign cnt_valid = vcnt_tree[1];
    assign cnt_old = ocnt_tree[1];
    assign min_keep = min_tree[1];

    assign run_expiry = $signed({2'b00, oldest_reg}) < cutoff;

    always_comb
    begin
        cmd = '0;
        cmd.pid = pid_reg;
        cmd.epoch = epoch_reg;
        cmd.seq = lseq_reg;
        cmd.wtime = act_reg ? btime_reg : now_reg;
        cmd.cutoff = cutoff;
        cmd.probe = state_reg == S_DECIDE ? 1'b0 : 1'b1;
        if (state_reg == S_DECIDE && take_reg)
        begin
            cmd.write_hit = wr_hit;
            cmd.write_new = wr_new;
        end
        if (state_reg == S_EXPIRE)
            cmd.expire = run_expiry;
        if (state_reg != S_IDLE && state_reg != S_OUT)
            cmd.probe = 1'b0;
    end

    always_comb
    begin
        oldest_next = oldest_reg;
        if (state_reg == S_DECIDE && take_reg && (wr_hit || wr_new) && cmd.wtime < oldest_reg)
            oldest_next = cmd.wtime;
        if (state_reg == S_EXPIRE && run_expiry)
            oldest_next = min_keep;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_DECIDE;
            S_DECIDE: state_next = (take_reg && act_reg) ? S_EXPIRE : S_COUNT;
            S_EXPIRE: state_next = S_COUNT;
            S_COUNT:  state_next = S_OUT;
            S_OUT:
                if (accept) state_next = S_DECIDE;
                else if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            window_reg <= EXPIRY_RESET;
            oldest_reg <= TIME_MAX;
        end
        else
        begin
            state_reg <= state_next;
            oldest_reg <= oldest_next;
            if (cfg_we)
                window_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            take_reg <= idempotent && ordered && (!action || is_data_batch);
            pid_reg <= producer_id;
            epoch_reg <= producer_epoch;
            fseq_reg <= seq_first;
            lseq_reg <= seq_last;
            btime_reg <= batch_time;
            now_reg <= now_time;
            removed_reg <= '0;
        end
        if (state_reg == S_DECIDE)
            status_reg <= take_reg ? status_next : ST_BYPASSED;
        if (state_reg == S_EXPIRE && run_expiry)
            removed_reg <= cnt_old;
        if (state_reg == S_COUNT)
            used_reg <= cnt_valid;
    end

    assign out_valid = state_reg == S_OUT;
    assign status = status_reg;
    assign entries_in_use = OUT_CNT_W'(used_reg);
    assign expired_count = OUT_CNT_W'(removed_reg);
endmodule
`default_nettype wire

// File: rtl/psdt_checker.sv
// Port-level assertions for the producer sequence dedup table
`default_nettype none
`include "producer_sequence_dedup_table_defines.svh"
module psdt_checker
    import psdt_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] status,
    input wire logic [6:0] entries_in_use,
    input wire logic [6:0] expired_count
);
    `PSDT_ASSERT_IMPL(a_used_range, clk, rst_n, out_valid, entries_in_use <= 7'(TABLE_ENTRIES), "entries out of range")
    `PSDT_ASSERT_IMPL(a_no_expiry_on_fail, clk, rst_n, out_valid && (status == ST_OUT_OF_ORDER), expired_count == 7'd0, "expiry on produce check")
    `PSDT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !out_valid, "result too early")
    `PSDT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status), "result dropped")
endmodule
bind producer_sequence_dedup_table psdt_checker u_psdt_checker (.*);
`default_nettype wire
